// ===== design/i2cm_pkg.sv =====
// shared types and constants for the i2c master byte engine
package i2cm_pkg;

    localparam int unsigned HP_W       = 10;
    localparam logic [HP_W-1:0] HP_RESET = 10'd4;
    localparam int unsigned PADDR_W    = 3;
    localparam logic [PADDR_W-1:0] ADDR_HALF_PERIOD = 3'd0;
    localparam int unsigned BITS_PER_BYTE = 8;
    localparam logic [3:0] ACK_BIT_IDX = 4'd8;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_RS_A = 5'd1,
        PH_RS_B = 5'd2,
        PH_RS_C = 5'd3,
        PH_ST_A = 5'd4,
        PH_ST_B = 5'd5,
        PH_WB_A = 5'd6,
        PH_WB_B = 5'd7,
        PH_WB_C = 5'd8,
        PH_RB_A = 5'd9,
        PH_RB_B = 5'd10,
        PH_RB_C = 5'd11,
        PH_SP_A = 5'd12,
        PH_SP_B = 5'd13,
        PH_SP_C = 5'd14,
        PH_SP_D = 5'd15,
        PH_SP_E = 5'd16
    } phase_t;

    // bit positions in pending flags
    localparam int unsigned FL_STOP = 0;
    localparam int unsigned FL_ACK  = 1;
    localparam int unsigned FL_READ = 2;

    typedef struct packed {
        func_t      kind;
        logic [7:0] data_byte;
        logic       send_start;
        logic       send_stop;
        logic       ack_to_send;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
        logic       arb_lost;
    } res_t;

endpackage

// ===== design/i2cm_cfg.sv =====
// apb register file holding the half period setting
module i2cm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [i2cm_pkg::HP_W-1:0]     half_period
);

    logic [i2cm_pkg::HP_W-1:0] half_period_reg;
    logic                      hit;

    assign pready = 1'b1;
    assign hit    = (paddr == i2cm_pkg::ADDR_HALF_PERIOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cm_pkg::HP_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            half_period_reg <= pwdata[i2cm_pkg::HP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (hit)
        begin
            prdata = {{(32-i2cm_pkg::HP_W){1'b0}}, half_period_reg};
        end
    end

    assign half_period = half_period_reg;

endmodule

// ===== design/i2cm_front.sv =====
// input side: takes items, classifies the function code and queues them
module i2cm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           func,
    input  logic [7:0]           data_byte,
    input  logic                 send_start,
    input  logic                 send_stop,
    input  logic                 ack_to_send,
    input  logic                 scl_in,
    input  logic                 sda_in,
    output logic                 item_valid,
    output i2cm_pkg::item_t      item,
    input  logic                 item_take
);

    i2cm_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push;
    logic            do_pop;
    i2cm_pkg::item_t in_item;

    always_comb
    begin
        in_item.kind        = i2cm_pkg::func_t'(func);
        in_item.data_byte   = data_byte;
        in_item.send_start  = send_start;
        in_item.send_stop   = send_stop;
        in_item.ack_to_send = ack_to_send;
        in_item.scl_in      = scl_in;
        in_item.sda_in      = sda_in;
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/i2cm_engine.sv =====
// bus engine: runs the phase machine, one queued item per cycle while res_room is high
module i2cm_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [i2cm_pkg::HP_W-1:0]  half_period,
    input  logic                       item_valid,
    input  i2cm_pkg::item_t            item,
    output logic                       item_take,
    input  logic                       res_room,
    output i2cm_pkg::res_t             res
);

    i2cm_pkg::phase_t          phase_reg, phase_next;
    logic [3:0]                bit_count_reg, bit_count_next;
    logic [7:0]                shift_reg, shift_next;
    logic [i2cm_pkg::HP_W-1:0] tick_reg, tick_next;
    logic                      bus_held_reg, bus_held_next;
    logic [2:0]                flags_reg, flags_next;
    logic                      scl_low_reg, scl_low_next;
    logic                      sda_low_reg, sda_low_next;
    logic [7:0]                rx_reg, rx_next;
    logic                      nack_reg, nack_next;
    logic                      arb_reg, arb_next;

    logic [i2cm_pkg::HP_W-1:0] hp;
    logic [i2cm_pkg::HP_W-1:0] tick_inc;
    logic                      over;
    logic                      enter_en;
    i2cm_pkg::phase_t          enter_ph;
    logic                      begin_en;
    logic                      next_bit_en;
    logic                      done;
    logic                      writing;
    logic                      cur_bit_now;
    logic                      cur_bit_new;

    function automatic logic cur_bit(input logic [3:0] bc, input logic [7:0] sb,
                                     input logic [2:0] fl);
        logic r;
        if (bc < i2cm_pkg::ACK_BIT_IDX)
        begin
            r = sb[7];
        end
        else
        begin
            r = fl[i2cm_pkg::FL_ACK];
        end
        return r;
    endfunction

    assign item_take   = item_valid && res_room;
    assign hp          = (half_period == '0) ? {{(i2cm_pkg::HP_W-1){1'b0}}, 1'b1} : half_period;
    assign tick_inc    = tick_reg + {{(i2cm_pkg::HP_W-1){1'b0}}, 1'b1};
    assign over        = (tick_inc >= hp);
    assign cur_bit_now = cur_bit(bit_count_reg, shift_reg, flags_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        bus_held_next  = bus_held_reg;
        flags_next     = flags_reg;
        scl_low_next   = scl_low_reg;
        sda_low_next   = sda_low_reg;
        rx_next        = rx_reg;
        nack_next      = nack_reg;
        arb_next       = arb_reg;
        enter_en       = 1'b0;
        enter_ph       = i2cm_pkg::PH_IDLE;
        begin_en       = 1'b0;
        next_bit_en    = 1'b0;
        done           = 1'b0;
        writing        = 1'b0;
        cur_bit_new    = 1'b0;

        priority if (item.kind == i2cm_pkg::FUNC_TICK && phase_reg != i2cm_pkg::PH_IDLE)
        begin
            unique case (phase_reg)
                i2cm_pkg::PH_RS_A, i2cm_pkg::PH_RS_C, i2cm_pkg::PH_WB_A,
                i2cm_pkg::PH_WB_B, i2cm_pkg::PH_RB_A, i2cm_pkg::PH_SP_A,
                i2cm_pkg::PH_SP_C, i2cm_pkg::PH_SP_D:
                begin
                    tick_next = tick_inc;
                    if (over)
                    begin
                        enter_en = 1'b1;
                        // timed phases step to the next, but PH_RS_C goes to PH_ST_A
                        enter_ph = i2cm_pkg::phase_t'(phase_reg + 5'd1);
                        if (phase_reg == i2cm_pkg::PH_RS_C)
                        begin
                            enter_ph = i2cm_pkg::PH_ST_A;
                        end
                    end
                end
                i2cm_pkg::PH_RS_B, i2cm_pkg::PH_RB_B, i2cm_pkg::PH_SP_B:
                begin
                    // wait out clock stretching
                    if (item.scl_in)
                    begin
                        enter_en = 1'b1;
                        enter_ph = i2cm_pkg::phase_t'(phase_reg + 5'd1);
                    end
                end
                i2cm_pkg::PH_ST_A:
                begin
                    if (!item.sda_in)
                    begin
                        arb_next = 1'b1;
                    end
                    enter_en = 1'b1;
                    enter_ph = i2cm_pkg::PH_ST_B;
                end
                i2cm_pkg::PH_ST_B:
                begin
                    tick_next = tick_inc;
                    if (over)
                    begin
                        scl_low_next   = 1'b1;
                        bus_held_next  = 1'b1;
                        bit_count_next = 4'd0;
                        begin_en       = 1'b1;
                    end
                end
                i2cm_pkg::PH_WB_C:
                begin
                    if (item.scl_in)
                    begin
                        if (cur_bit_now && !item.sda_in)
                        begin
                            arb_next = 1'b1;
                        end
                        scl_low_next = 1'b1;
                        if (bit_count_reg < i2cm_pkg::ACK_BIT_IDX)
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                        next_bit_en = 1'b1;
                    end
                end
                i2cm_pkg::PH_RB_C:
                begin
                    tick_next = tick_inc;
                    if (over)
                    begin
                        if (bit_count_reg < i2cm_pkg::ACK_BIT_IDX)
                        begin
                            shift_next = {shift_reg[6:0], item.sda_in};
                        end
                        else
                        begin
                            nack_next = item.sda_in;
                        end
                        scl_low_next = 1'b1;
                        next_bit_en  = 1'b1;
                    end
                end
                i2cm_pkg::PH_SP_E:
                begin
                    if (!item.sda_in)
                    begin
                        arb_next = 1'b1;
                    end
                    bus_held_next = 1'b0;
                    enter_en      = 1'b1;
                    enter_ph      = i2cm_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                default:
                begin
                    phase_next = i2cm_pkg::PH_IDLE;
                end
            endcase
        end
        else if ((item.kind == i2cm_pkg::FUNC_WRITE || item.kind == i2cm_pkg::FUNC_READ)
                 && phase_reg == i2cm_pkg::PH_IDLE)
        begin
            flags_next[i2cm_pkg::FL_STOP] = item.send_stop;
            flags_next[i2cm_pkg::FL_ACK]  = item.ack_to_send;
            flags_next[i2cm_pkg::FL_READ] = (item.kind == i2cm_pkg::FUNC_READ);
            shift_next     = (item.kind == i2cm_pkg::FUNC_WRITE) ? item.data_byte : 8'd0;
            bit_count_next = 4'd0;
            nack_next      = 1'b0;
            arb_next       = 1'b0;
            if (item.send_start)
            begin
                enter_en = 1'b1;
                enter_ph = bus_held_reg ? i2cm_pkg::PH_RS_A : i2cm_pkg::PH_ST_A;
            end
            else
            begin
                begin_en = 1'b1;
            end
        end
        else
        begin
            // idle tick, unused code or command while busy: report state only
        end

        if (next_bit_en)
        begin
            bit_count_next = bit_count_reg + 4'd1;
            if (bit_count_next <= i2cm_pkg::ACK_BIT_IDX)
            begin
                begin_en = 1'b1;
            end
            else
            begin
                if (flags_next[i2cm_pkg::FL_READ])
                begin
                    rx_next = shift_next;
                end
                enter_en = 1'b1;
                if (flags_next[i2cm_pkg::FL_STOP])
                begin
                    enter_ph = i2cm_pkg::PH_SP_A;
                end
                else
                begin
                    enter_ph = i2cm_pkg::PH_IDLE;
                    done     = 1'b1;
                end
            end
        end

        if (begin_en)
        begin
            // read commands write only the ack bit, write commands only the data bits
            writing  = flags_next[i2cm_pkg::FL_READ] ? (bit_count_next == i2cm_pkg::ACK_BIT_IDX)
                                                     : (bit_count_next < i2cm_pkg::ACK_BIT_IDX);
            enter_en = 1'b1;
            enter_ph = writing ? i2cm_pkg::PH_WB_A : i2cm_pkg::PH_RB_A;
        end

        if (enter_en)
        begin
            phase_next  = enter_ph;
            tick_next   = '0;
            cur_bit_new = cur_bit(bit_count_next, shift_next, flags_next);
            unique case (enter_ph)
                i2cm_pkg::PH_RS_A, i2cm_pkg::PH_RB_A, i2cm_pkg::PH_SP_D:
                    sda_low_next = 1'b0;
                i2cm_pkg::PH_RS_B, i2cm_pkg::PH_WB_B, i2cm_pkg::PH_RB_B, i2cm_pkg::PH_SP_B:
                    scl_low_next = 1'b0;
                i2cm_pkg::PH_ST_B, i2cm_pkg::PH_SP_A:
                    sda_low_next = 1'b1;
                i2cm_pkg::PH_WB_A:
                    sda_low_next = !cur_bit_new;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res.scl_pull_low = scl_low_next;
        res.sda_pull_low = sda_low_next;
        res.busy_res     = (phase_next != i2cm_pkg::PH_IDLE);
        res.done_res     = done;
        res.rx_byte      = rx_next;
        res.nack_seen    = nack_next;
        res.arb_lost     = arb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            tick_reg      <= '0;
            bus_held_reg  <= 1'b0;
            flags_reg     <= 3'd0;
            scl_low_reg   <= 1'b0;
            sda_low_reg   <= 1'b0;
            rx_reg        <= 8'd0;
            nack_reg      <= 1'b0;
            arb_reg       <= 1'b0;
        end
        else if (item_take)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            bus_held_reg  <= bus_held_next;
            flags_reg     <= flags_next;
            scl_low_reg   <= scl_low_next;
            sda_low_reg   <= sda_low_next;
            rx_reg        <= rx_next;
            nack_reg      <= nack_next;
            arb_reg       <= arb_next;
        end
    end

endmodule

// ===== design/i2cm_resq.sv =====
// two-entry result queue in front of the output ports
module i2cm_resq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_push,
    input  i2cm_pkg::res_t  res,
    output logic            res_room,
    output logic            empty,
    input  logic            pop,
    output i2cm_pkg::res_t  head
);

    i2cm_pkg::res_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign res_room = (count_reg != 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = mem_reg[rd_ptr_reg];
    assign do_push  = res_push && res_room;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== design/i2c_master_byte_engine.sv =====
// top level of the i2c master byte engine
//
//   channel   handshake              contents
//   input     push / full            func, data_byte, start/stop/ack flags, pin samples
//   result    empty / pop            line drives, busy, done, rx byte, nack, arb lost
//   config    apb psel/penable       half_period_ticks at byte address 0
//
// one item per clock while results have room: the front queue and the result queue are
// the register stages, with the phase machine between them retiring queued items.
// a result is written to the result queue as its item leaves the front queue.
// both queues hold two items, so full rises only when results are not popped.
// reset releases both lines, clears the queues and loads a half period of four ticks.
module i2c_master_byte_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    func,
    input  logic [7:0]                    data_byte,
    input  logic                          send_start,
    input  logic                          send_stop,
    input  logic                          ack_to_send,
    input  logic                          scl_in,
    input  logic                          sda_in,
    output logic                          empty,
    input  logic                          pop,
    output logic                          scl_pull_low,
    output logic                          sda_pull_low,
    output logic                          busy_res,
    output logic                          done_res,
    output logic [7:0]                    rx_byte,
    output logic                          nack_seen,
    output logic                          arb_lost
);

    logic [i2cm_pkg::HP_W-1:0] half_period;
    logic                      item_valid;
    i2cm_pkg::item_t           item;
    logic                      item_take;
    logic                      res_room;
    i2cm_pkg::res_t            res;
    i2cm_pkg::res_t            head;

    i2cm_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .half_period (half_period)
    );

    i2cm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .data_byte   (data_byte),
        .send_start  (send_start),
        .send_stop   (send_stop),
        .ack_to_send (ack_to_send),
        .scl_in      (scl_in),
        .sda_in      (sda_in),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    i2cm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_period (half_period),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .res_room    (res_room),
        .res         (res)
    );

    i2cm_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (item_take),
        .res      (res),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign scl_pull_low = head.scl_pull_low;
    assign sda_pull_low = head.sda_pull_low;
    assign busy_res     = head.busy_res;
    assign done_res     = head.done_res;
    assign rx_byte      = head.rx_byte;
    assign nack_seen    = head.nack_seen;
    assign arb_lost     = head.arb_lost;

endmodule

// ===== design/i2cm_checker.sv =====
// port-level checks for the i2c master byte engine, bound to the top level
module i2cm_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  logic       pop,
    input  logic       scl_pull_low,
    input  logic       sda_pull_low,
    input  logic       busy_res,
    input  logic       done_res,
    input  logic [7:0] rx_byte
);

    // a completing item always leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // idle with scl released only follows a stop or reset, so sda is released too
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !busy_res && !scl_pull_low |-> !sda_pull_low)
        else $error("sda held low on an idle released bus");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before pop");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(rx_byte) && $stable(done_res))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .scl_pull_low (scl_pull_low),
    .sda_pull_low (sda_pull_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .rx_byte      (rx_byte)
);
